### hw/rtl/tdil_pkg.sv
// shared types, codes and constants of the threshold and 3x3 dilation unit
package tdil_pkg;

  // pixel and configuration widths
  localparam int unsigned GRAY_W     = 8;
  localparam int unsigned SIZE_W     = 11;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned MIN_SIZE   = 3;

  // result queue geometry
  localparam int unsigned FIFO_DEPTH = 8;
  localparam int unsigned FIFO_PTR_W = 3;
  localparam int unsigned FIFO_CNT_W = 4;

  // output pixel levels
  localparam logic [GRAY_W-1:0] PIX_ON  = 8'd255;
  localparam logic [GRAY_W-1:0] PIX_OFF = 8'd0;

  // input item modes
  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_PAD   = 1'b1;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD    = 2'd0,
    CFG_FRAME_WIDTH  = 2'd1,
    CFG_FRAME_HEIGHT = 2'd2
  } cfg_idx_e;

  // one result item
  typedef struct packed {
    logic [GRAY_W-1:0] pixel;
    logic              eof;
  } res_t;

  // up to two results pushed by one input item, slot 0 first
  typedef struct packed {
    logic v0;
    res_t r0;
    logic v1;
    res_t r1;
  } push_t;

  // control of an item between the read issue and the window stage
  typedef struct packed {
    logic       valid;
    logic       flush;
    logic       last;
    logic       t;
    logic       r_ge1;
    logic       r_ge2;
    logic       c_ge1;
    logic       c_ge2;
    logic       fwd;
    logic [1:0] fwd_data;
  } issue_t;

  // build a result item from a binary pixel
  function automatic res_t make_res(input logic b, input logic eof);
    res_t r;
    r.pixel = b ? PIX_ON : PIX_OFF;
    r.eof   = eof;
    return r;
  endfunction

endpackage

### hw/rtl/tdil_in_if.sv
// pixel input channel: valid, ready and the input item fields
interface tdil_in_if import tdil_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              mode;
  logic [GRAY_W-1:0] gray;

  modport source (output valid, mode, gray, input ready);
  modport sink (input valid, mode, gray, output ready);
endinterface

### hw/rtl/tdil_out_if.sv
// result output channel: valid, ready and the result item fields
interface tdil_out_if import tdil_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [GRAY_W-1:0] out_pixel;
  logic              end_of_frame;

  modport source (output valid, out_pixel, end_of_frame, input ready);
  modport sink (input valid, out_pixel, end_of_frame, output ready);
endinterface

### hw/rtl/tdil_row_ram.sv
// line buffer memory: per column the two previous thresholded rows, registered read
module tdil_row_ram #(
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned ADDR_W = 10
) (
  input  logic              clk_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [1:0]        rd_data_o,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [1:0]        wr_data_i
);

  // bit 0 older row, bit 1 newer row
  logic [1:0] mem [DEPTH];
  logic [1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // read port, registered
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### hw/rtl/tdil_ctrl.sv
// input side: raster counters, flush sequencing, line buffer read issue and forwarding
module tdil_ctrl import tdil_pkg::*; #(
  parameter int unsigned COL_W = 10,
  parameter int unsigned ROW_W = 11
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_mode_i,
  input  logic [GRAY_W-1:0]     in_gray_i,
  output logic                  in_ready_o,
  input  logic [GRAY_W-1:0]     thr_i,
  input  logic [COL_W-1:0]      wlast_i,
  input  logic [ROW_W-1:0]      height_i,
  input  logic [FIFO_CNT_W-1:0] fifo_cnt_i,
  input  logic                  wr_en_i,
  input  logic [COL_W-1:0]      wr_addr_i,
  input  logic [1:0]            wr_data_i,
  output logic                  rd_en_o,
  output logic [COL_W-1:0]      rd_addr_o,
  output issue_t                iss_o,
  output logic [COL_W-1:0]      iss_addr_o
);

  localparam logic [COL_W-1:0]      COL_ONE   = COL_W'(1);
  localparam logic [COL_W-1:0]      COL_TWO   = COL_W'(2);
  localparam logic [ROW_W-1:0]      ROW_ONE   = ROW_W'(1);
  localparam logic [ROW_W-1:0]      ROW_TWO   = ROW_W'(2);
  localparam logic [FIFO_CNT_W:0]   LVL_TWO   = (FIFO_CNT_W+1)'(2);
  localparam logic [FIFO_CNT_W:0]   LVL_DEPTH = (FIFO_CNT_W+1)'(FIFO_DEPTH);

  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [COL_W-1:0]  flush_q, flush_d;
  issue_t            iss_q, iss_d;
  logic [COL_W-1:0]  iss_addr_q;
  logic [COL_W-1:0]  rd_addr;
  logic [FIFO_CNT_W:0] lvl;
  logic              acc;
  logic              in_flush;

  // room for this item's results and those of the item in the window stage
  always_comb begin
    lvl = (FIFO_CNT_W+1)'(fifo_cnt_i) + (iss_q.valid ? LVL_TWO : '0) + LVL_TWO;
    in_ready_o = (lvl <= LVL_DEPTH);
  end

  // counters and read issue
  always_comb begin
    acc      = in_valid_i && in_ready_o;
    in_flush = (row_q >= height_i);
    col_d    = col_q;
    row_d    = row_q;
    flush_d  = flush_q;
    iss_d    = '0;
    rd_addr  = col_q;
    if (acc) begin
      if (in_flush) begin
        // flush of the last row, any item counts as a pad
        rd_addr     = flush_q;
        iss_d.valid = 1'b1;
        iss_d.flush = 1'b1;
        iss_d.last  = (flush_q >= wlast_i);
        if (flush_q >= wlast_i) begin
          row_d   = '0;
          col_d   = '0;
          flush_d = '0;
        end else begin
          flush_d = flush_q + COL_ONE;
        end
      end else if (in_mode_i == MODE_PIXEL) begin
        rd_addr     = col_q;
        iss_d.valid = 1'b1;
        iss_d.last  = (col_q >= wlast_i);
        iss_d.t     = (in_gray_i >= thr_i);
        iss_d.r_ge1 = (row_q >= ROW_ONE);
        iss_d.r_ge2 = (row_q >= ROW_TWO);
        iss_d.c_ge1 = (col_q >= COL_ONE);
        iss_d.c_ge2 = (col_q >= COL_TWO);
        if (col_q >= wlast_i) begin
          col_d = '0;
          row_d = row_q + ROW_ONE;
        end else begin
          col_d = col_q + COL_ONE;
        end
      end
    end
    // forward the write-back that lands in the same cycle as this read
    iss_d.fwd      = wr_en_i && (wr_addr_i == rd_addr);
    iss_d.fwd_data = wr_data_i;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      flush_q <= '0;
      iss_q   <= '0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      flush_q <= flush_d;
      iss_q   <= iss_d;
    end
  end

  // address of the item in the window stage
  always_ff @(posedge clk_i) begin
    if (iss_d.valid) begin
      iss_addr_q <= rd_addr;
    end
  end

  assign rd_en_o    = iss_d.valid;
  assign rd_addr_o  = rd_addr;
  assign iss_o      = iss_q;
  assign iss_addr_o = iss_addr_q;

endmodule

### hw/rtl/tdil_window.sv
// window stage: 3x3 window shift, line buffer write-back and result selection
module tdil_window import tdil_pkg::*; #(
  parameter int unsigned COL_W = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  issue_t           iss_i,
  input  logic [COL_W-1:0] iss_addr_i,
  input  logic [1:0]       rd_data_i,
  output logic             wr_en_o,
  output logic [COL_W-1:0] wr_addr_o,
  output logic [1:0]       wr_data_o,
  output push_t            push_o
);

  // bits 2:0 newest column (older, newer, current row), 8:6 oldest
  logic [8:0] win_q, win_d;
  logic [1:0] rd;
  logic       older;
  logic       newer;
  logic       main_bit;

  always_comb begin
    rd        = iss_i.fwd ? iss_i.fwd_data : rd_data_i;
    older     = rd[0];
    newer     = rd[1];
    win_d     = win_q;
    wr_en_o   = 1'b0;
    wr_data_o = {iss_i.t, newer};
    push_o    = '0;
    main_bit  = 1'b0;
    if (iss_i.valid && iss_i.flush) begin
      // last row goes out as it stands
      push_o.v0 = 1'b1;
      push_o.r0 = make_res(newer, iss_i.last);
      if (iss_i.last) begin
        win_d = '0;
      end
    end else if (iss_i.valid) begin
      win_d   = {win_q[5:0], iss_i.t, newer, older};
      wr_en_o = 1'b1;
      // interior pixels take the window, border pixels their own center
      main_bit = (iss_i.r_ge2 && iss_i.c_ge2) ? (|win_d) : win_d[4];
      if (iss_i.r_ge1 && iss_i.c_ge1) begin
        push_o.v0 = 1'b1;
        push_o.r0 = make_res(main_bit, 1'b0);
      end
      // right border pixel of the previous row
      if (iss_i.last && iss_i.r_ge1) begin
        if (iss_i.c_ge1) begin
          push_o.v1 = 1'b1;
          push_o.r1 = make_res(win_d[1], 1'b0);
        end else begin
          push_o.v0 = 1'b1;
          push_o.r0 = make_res(win_d[1], 1'b0);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else begin
      win_q <= win_d;
    end
  end

  assign wr_addr_o = iss_addr_i;

endmodule

### hw/rtl/tdil_res_fifo.sv
// result queue: takes up to two results a cycle, hands out one a cycle while the receiver is ready
module tdil_res_fifo import tdil_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  push_t                 push_i,
  input  logic                  pop_ready_i,
  output logic                  pop_valid_o,
  output res_t                  pop_item_o,
  output logic [FIFO_CNT_W-1:0] cnt_o
);

  localparam logic [FIFO_PTR_W-1:0] PTR_ONE = FIFO_PTR_W'(1);

  res_t                  buf_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_PTR_W-1:0] wr_ptr_nx;
  logic [FIFO_CNT_W-1:0] cnt_q, cnt_d;
  logic                  pop;

  always_comb begin
    pop       = pop_valid_o && pop_ready_i;
    wr_ptr_nx = wr_ptr_q + PTR_ONE;
    wr_ptr_d  = wr_ptr_q + FIFO_PTR_W'(push_i.v0) + FIFO_PTR_W'(push_i.v1);
    rd_ptr_d  = rd_ptr_q + FIFO_PTR_W'(pop);
    cnt_d     = cnt_q + FIFO_CNT_W'(push_i.v0) + FIFO_CNT_W'(push_i.v1)
              - FIFO_CNT_W'(pop);
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i.v0) begin
      buf_q[wr_ptr_q] <= push_i.r0;
    end
    if (push_i.v1) begin
      buf_q[wr_ptr_nx] <= push_i.r1;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  assign pop_valid_o = (cnt_q != '0);
  assign pop_item_o  = buf_q[rd_ptr_q];
  assign cnt_o       = cnt_q;

endmodule

### hw/rtl/threshold_dilate_3x3_unit.sv
// top level of the binary threshold and 3x3 dilation unit
//
// Gray pixels enter in raster order on in_i (mode 0); each is set when
// gray >= threshold. Results leave on out_o as 0 or 255, one row and one
// column behind the input: the OR of the 3x3 window inside the frame, the
// pixel's own value on the border. After the last row, frame_width further
// items of either mode flush that row; the last result carries end_of_frame.
// A pad item while pixels are expected is taken and dropped.
// Throughput: one input item per clock while in_i.ready holds. An accepted
// item's line buffer word and control are registered; the window stage then
// pushes the item's results into the queue, from which they leave on out_o.
// The line buffer is one memory of MAX_WIDTH words of two bits, read once per
// item that is not dropped and written back once per pixel item; a write-back
// to the word read in the same cycle is forwarded.
// Results wait in an 8-entry queue; when out_o stalls, in_i.ready drops as
// soon as the queue could not take the results of a further item.
// Reset clears the counters, the window and the queue and sets threshold 0,
// frame_width 640 and frame_height 480; the line buffer is not cleared.
// Configuration is written through cfg_we_i, cfg_idx_i and cfg_data_i.
module threshold_dilate_3x3_unit import tdil_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  tdil_in_if.sink               in_i,
  tdil_out_if.source            out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W = $clog2(MAX_HEIGHT + 1);

  logic [GRAY_W-1:0]     thr_q;
  logic [SIZE_W-1:0]     width_q;
  logic [SIZE_W-1:0]     height_q;
  logic [COL_W-1:0]      wlast;
  logic [ROW_W-1:0]      height;
  logic [FIFO_CNT_W-1:0] fifo_cnt;
  logic                  rd_en;
  logic [COL_W-1:0]      rd_addr;
  logic [1:0]            rd_data;
  logic                  wr_en;
  logic [COL_W-1:0]      wr_addr;
  logic [1:0]            wr_data;
  issue_t                iss;
  logic [COL_W-1:0]      iss_addr;
  push_t                 push;
  res_t                  head;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= '0;
      width_q  <= SIZE_W'(640);
      height_q <= SIZE_W'(480);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_THRESHOLD:    thr_q    <= cfg_data_i[GRAY_W-1:0];
        CFG_FRAME_WIDTH:  width_q  <= cfg_data_i[SIZE_W-1:0];
        CFG_FRAME_HEIGHT: height_q <= cfg_data_i[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // frame size clamped to the supported range
  always_comb begin
    if (width_q < SIZE_W'(MIN_SIZE)) begin
      wlast = COL_W'(MIN_SIZE - 1);
    end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
      wlast = COL_W'(MAX_WIDTH - 1);
    end else begin
      wlast = COL_W'(width_q - SIZE_W'(1));
    end
    if (height_q < SIZE_W'(MIN_SIZE)) begin
      height = ROW_W'(MIN_SIZE);
    end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
      height = ROW_W'(MAX_HEIGHT);
    end else begin
      height = ROW_W'(height_q);
    end
  end

  tdil_ctrl #(
    .COL_W (COL_W),
    .ROW_W (ROW_W)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_mode_i  (in_i.mode),
    .in_gray_i  (in_i.gray),
    .in_ready_o (in_i.ready),
    .thr_i      (thr_q),
    .wlast_i    (wlast),
    .height_i   (height),
    .fifo_cnt_i (fifo_cnt),
    .wr_en_i    (wr_en),
    .wr_addr_i  (wr_addr),
    .wr_data_i  (wr_data),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr),
    .iss_o      (iss),
    .iss_addr_o (iss_addr)
  );

  tdil_row_ram #(
    .DEPTH  (MAX_WIDTH),
    .ADDR_W (COL_W)
  ) u_row_ram (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  tdil_window #(
    .COL_W (COL_W)
  ) u_window (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .iss_i      (iss),
    .iss_addr_i (iss_addr),
    .rd_data_i  (rd_data),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data),
    .push_o     (push)
  );

  tdil_res_fifo u_res_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .pop_ready_i (out_o.ready),
    .pop_valid_o (out_o.valid),
    .pop_item_o  (head),
    .cnt_o       (fifo_cnt)
  );

  assign out_o.out_pixel    = head.pixel;
  assign out_o.end_of_frame = head.eof;

endmodule

### hw/rtl/tdil_checker.sv
// port-level checks of the threshold and dilation unit, bound to the top level
module tdil_checker import tdil_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [GRAY_W-1:0] out_pixel_i,
  input logic              out_eof_i
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  // results are binary
  a_pixel_binary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_pixel_i == PIX_ON || out_pixel_i == PIX_OFF))
    else $error("output pixel is neither 0 nor 255");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(out_pixel_i) && $stable(out_eof_i)))
    else $error("stalled result changed or vanished");

  // no result appears without an item accepted before it
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_i && !$past(in_acc)) |=> !out_valid_i)
    else $error("result appeared without an accepted item");

  // with nothing queued and nothing in flight the input is open
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_i && !$past(in_acc)) |-> in_ready_i)
    else $error("input stalled while the block holds no work");

endmodule

bind threshold_dilate_3x3_unit tdil_checker u_tdil_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_pixel_i (out_o.out_pixel),
  .out_eof_i   (out_o.end_of_frame)
);

### tb/tb_threshold_dilate_3x3_unit.sv
// testbench of the threshold and 3x3 dilation unit: line buffer predictor, directed and random frames
module tb_threshold_dilate_3x3_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import tdil_pkg::*;

  localparam int unsigned LINE_MAX     = 1024;
  localparam int unsigned ROW_MAX      = 1024;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned SHOW_MAX     = 10;

  logic                  clk_i  = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  tdil_in_if  in_if ();
  tdil_out_if out_if ();

  threshold_dilate_3x3_unit #(
    .MAX_WIDTH  (LINE_MAX),
    .MAX_HEIGHT (ROW_MAX)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // mirror of the configuration and the line buffer state
  logic [GRAY_W-1:0] thr_q    = '0;
  logic [SIZE_W-1:0] width_q  = 11'd640;
  logic [SIZE_W-1:0] height_q = 11'd480;
  bit                older_row [LINE_MAX];
  bit                newer_row [LINE_MAX];
  logic [8:0]        win_q    = '0;
  int unsigned       row_q    = 0;
  int unsigned       col_q    = 0;
  int unsigned       flush_q  = 0;

  res_t dilated_q [$];
  res_t head_pixel;
  int   items_taken    = 0;
  int   mismatch_count = 0;
  int   idle_cycles    = 0;
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;

  function automatic int unsigned clamp_dim(input logic [SIZE_W-1:0] v, input int unsigned hi);
    if (v < MIN_SIZE) return MIN_SIZE;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void push_pixel(input logic b, input logic eof);
    res_t r;
    r.pixel = b ? PIX_ON : PIX_OFF;
    r.eof   = eof;
    dilated_q.push_back(r);
  endfunction

  // expected results of one accepted item
  function automatic void dilate_item(input logic m, input logic [GRAY_W-1:0] g);
    int unsigned w, h, c, r;
    logic        t, o, nw;
    w = clamp_dim(width_q, LINE_MAX);
    h = clamp_dim(height_q, ROW_MAX);
    // flush of the last row, whatever the mode
    if (row_q >= h) begin
      items_taken++;
      if (flush_q >= w - 1) begin
        push_pixel(newer_row[flush_q], 1'b1);
        row_q   = 0;
        col_q   = 0;
        flush_q = 0;
        win_q   = '0;
      end else begin
        push_pixel(newer_row[flush_q], 1'b0);
        flush_q++;
      end
      return;
    end
    // pad item while pixels are expected is dropped
    if (m == MODE_PAD) return;
    items_taken++;
    c  = col_q;
    r  = row_q;
    t  = (g >= thr_q);
    o  = older_row[c];
    nw = newer_row[c];
    older_row[c] = nw;
    newer_row[c] = t;
    win_q = {win_q[5:0], t, nw, o};
    if (r >= 1 && c >= 1) begin
      push_pixel((r >= 2 && c >= 2) ? |win_q : win_q[4], 1'b0);
    end
    // end of row also emits the last column of the row above
    if (c >= w - 1) begin
      if (r >= 1) push_pixel(win_q[1], 1'b0);
      col_q = 0;
      row_q = r + 1;
    end else begin
      col_q = c + 1;
    end
  endfunction

  // result check and stall watchdog, sampled away from the clock edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (dilated_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= SHOW_MAX) begin
            $display("unexpected item: pixel %0d eof %0b", out_if.out_pixel,
                     out_if.end_of_frame);
          end
        end else begin
          head_pixel = dilated_q.pop_front();
          if (out_if.out_pixel !== head_pixel.pixel ||
              out_if.end_of_frame !== head_pixel.eof) begin
            mismatch_count++;
            if (mismatch_count <= SHOW_MAX) begin
              $display("mismatch: pixel expected %0d actual %0d, eof expected %0b actual %0b",
                       head_pixel.pixel, out_if.out_pixel, head_pixel.eof,
                       out_if.end_of_frame);
            end
          end
        end
      end
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // receiver stalls
  always @(posedge clk_i) begin
    out_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  task automatic send_item(input logic m, input logic [GRAY_W-1:0] g);
    logic taken;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.mode  <= m;
    in_if.gray  <= g;
    do begin
      @(negedge clk_i);
      taken = in_if.ready;
      @(posedge clk_i);
    end while (!taken);
    dilate_item(m, g);
  endtask

  // hold the sender until every expected result is out
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (dilated_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] v);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_THRESHOLD:    thr_q = v[GRAY_W-1:0];
      CFG_FRAME_WIDTH:  width_q = v;
      CFG_FRAME_HEIGHT: height_q = v;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_frame(input logic [GRAY_W-1:0] thr, input logic [SIZE_W-1:0] w,
                           input logic [SIZE_W-1:0] h);
    cfg_write(CFG_THRESHOLD, 11'(thr));
    cfg_write(CFG_FRAME_WIDTH, w);
    cfg_write(CFG_FRAME_HEIGHT, h);
  endtask

  // gray value that is set with a chance of dens percent, always set at threshold 0
  function automatic logic [GRAY_W-1:0] pick_gray(input int dens);
    if (thr_q == 0 || $urandom_range(0, 99) < dens) begin
      return 8'($urandom_range(int'(thr_q), 255));
    end
    return 8'($urandom_range(0, int'(thr_q) - 1));
  endfunction

  task automatic send_pixels(input int unsigned n, input int dens);
    repeat (n) send_item(MODE_PIXEL, pick_gray(dens));
  endtask

  // rest of the frame, pad noise among the pixels and pixel-mode items in the flush
  task automatic finish_frame(input int dens, input int noise_pct);
    while (row_q < clamp_dim(height_q, ROW_MAX)) begin
      if ($urandom_range(0, 99) < noise_pct) send_item(MODE_PAD, 8'($urandom));
      else send_item(MODE_PIXEL, pick_gray(dens));
    end
    while (row_q >= clamp_dim(height_q, ROW_MAX)) begin
      send_item(($urandom_range(0, 99) < noise_pct * 5) ? MODE_PIXEL : MODE_PAD,
                8'($urandom));
    end
  endtask

  // threshold left at reset: every pixel is set
  task automatic test_reset_threshold();
    cfg_write(CFG_FRAME_WIDTH, 11'd3);
    cfg_write(CFG_FRAME_HEIGHT, 11'd3);
    for (int i = 0; i < 9; i++) send_item(MODE_PIXEL, (i % 2) ? 8'd0 : 8'd255);
    finish_frame(0, 0);
    wait_idle();
  endtask

  // small frame with gray extremes around the threshold, a dropped pad and a mixed flush
  task automatic test_directed_frame();
    logic [GRAY_W-1:0] plan [12];
    plan = '{8'd255, 8'd0, 8'd0, 8'd128,
             8'd0, 8'd127, 8'd0, 8'd0,
             8'd0, 8'd0, 8'd0, 8'd200};
    set_frame(8'd128, 11'd4, 11'd3);
    for (int i = 0; i < 12; i++) begin
      send_item(MODE_PIXEL, plan[i]);
      if (i == 5) send_item(MODE_PAD, 8'd255);
    end
    send_item(MODE_PAD, 8'd0);
    send_item(MODE_PIXEL, 8'd255);
    send_item(MODE_PAD, 8'd255);
    send_item(MODE_PIXEL, 8'd0);
    wait_idle();
  endtask

  // width narrowed in row 2, height cut in row 3 so the flush starts early
  task automatic test_mid_frame_change();
    set_frame(8'd100, 11'd8, 11'd6);
    send_pixels(19, 20);
    wait_idle();
    cfg_write(CFG_FRAME_WIDTH, 11'd5);
    cfg_write(CFG_THRESHOLD, 11'd200);
    while (!(row_q == 3 && col_q == 2)) send_item(MODE_PIXEL, pick_gray(30));
    wait_idle();
    cfg_write(CFG_FRAME_HEIGHT, 11'd3);
    finish_frame(30, 5);
    wait_idle();
  endtask

  // width clamped from above over one full row, then narrowed; sizes clamped from below
  task automatic test_size_limits();
    set_frame(8'd60, 11'd2047, 11'd2);
    send_pixels(LINE_MAX, 5);
    wait_idle();
    cfg_write(CFG_FRAME_WIDTH, 11'd4);
    finish_frame(5, 0);
    wait_idle();
    set_frame(8'd255, 11'd1, 11'd1);
    finish_frame(5, 0);
    wait_idle();
    set_frame(8'd0, 11'd0, 11'd0);
    finish_frame(30, 0);
    wait_idle();
  endtask

  // random frames, mostly small, with random sizes, thresholds and pixel density
  task automatic test_random_frames(input int send_pct, input int recv_pct, input int n_items);
    int target, dens, w, h, thr, pick;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    target = items_taken + n_items;
    while (items_taken < target) begin
      wait_idle();
      case ($urandom_range(0, 9))
        0:       thr = 0;
        1:       thr = 255;
        default: thr = $urandom_range(1, 254);
      endcase
      pick = $urandom_range(0, 19);
      if (pick < 2) w = $urandom_range(0, 2);
      else if (pick == 2) w = $urandom_range(11, 40);
      else w = $urandom_range(3, 10);
      h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 7);
      case ($urandom_range(0, 3))
        0:       dens = 3;
        1:       dens = 15;
        2:       dens = 40;
        default: dens = 80;
      endcase
      set_frame(8'(thr), 11'(w), 11'(h));
      // now and then drain in the first row and move the threshold
      if ($urandom_range(0, 7) == 0) begin
        send_pixels($urandom_range(1, clamp_dim(width_q, LINE_MAX)), dens);
        wait_idle();
        cfg_write(CFG_THRESHOLD, 11'($urandom_range(0, 255)));
      end
      finish_frame(dens, 5);
    end
    wait_idle();
  endtask

  initial begin
    in_if.valid  = 1'b0;
    in_if.mode   = MODE_PIXEL;
    in_if.gray   = '0;
    out_if.ready = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = CFG_THRESHOLD;
    cfg_data_i   = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_threshold();
    test_directed_frame();
    test_mid_frame_change();
    test_size_limits();
    test_random_frames(0, 0, 40);
    test_random_frames(76, 0, 40);
    test_random_frames(0, 76, 40);
    test_random_frames(15, 15, 40);

    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/tdil_pkg.sv
hw/rtl/tdil_in_if.sv
hw/rtl/tdil_out_if.sv
hw/rtl/tdil_row_ram.sv
hw/rtl/tdil_ctrl.sv
hw/rtl/tdil_window.sv
hw/rtl/tdil_res_fifo.sv
hw/rtl/threshold_dilate_3x3_unit.sv
hw/rtl/tdil_checker.sv
tb/tb_threshold_dilate_3x3_unit.sv
